// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hdl/fpalu_pkg.sv =====
`default_nettype none

package fpalu_pkg;

  localparam int DataW     = 32;
  localparam int FracBits  = 8;
  localparam int WordWidth = 32;
  localparam int CmdW      = 4;

  // wide enough for a full product plus sign and carry
  localparam int WideW = 2 * DataW + 2;

  localparam int QuoW         = DataW + FracBits;
  localparam int DivRadixBits = 4;
  localparam int DivStages    = (QuoW + DivRadixBits - 1) / DivRadixBits;

  localparam logic signed [WideW-1:0] SatMax =
    {{(WideW - WordWidth + 1){1'b0}}, {(WordWidth - 1){1'b1}}};
  localparam logic signed [WideW-1:0] SatMin = ~SatMax;

  typedef enum logic [CmdW-1:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdCompare = 4'd4,
    CmdMin     = 4'd5,
    CmdMax     = 4'd6,
    CmdInc     = 4'd7,
    CmdDec     = 4'd8,
    CmdToInt   = 4'd9,
    CmdFromInt = 4'd10
  } cmd_e;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic             ovf;
  } sat_t;

  typedef struct packed {
    logic             vld;
    logic [CmdW-1:0]  cmd;
    logic             lt;
    logic             eq;
    logic             gt;
    logic [DataW-1:0] res;
    logic             ovf;
    logic             neg;
    logic [QuoW-1:0]  nq;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] den;
  } pipe_t;

  function automatic sat_t sat_fn(input logic signed [WideW-1:0] v);
    sat_t r;
    r.ovf = 1'b0;
    if (v > SatMax) begin
      r.res = SatMax[DataW-1:0];
      r.ovf = 1'b1;
    end else if (v < SatMin) begin
      r.res = SatMin[DataW-1:0];
      r.ovf = 1'b1;
    end else begin
      r.res = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fixed_point_alu.sv =====
`default_nettype none
// A result passes the input, setup, divider and output registers in that order.
// Throughput: one transaction per cycle; busy never rises, the pipeline always advances.
// The divider resolves 4 quotient bits per stage over 10 stages and sets the depth.
// Reset clears only the valid bits; payload registers hold whatever they had.
// The receiver cannot stall: each result shows for exactly one cycle.

module fixed_point_alu (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [fpalu_pkg::CmdW-1:0]   cmd_i,
  input  wire  [fpalu_pkg::DataW-1:0]  operand_a_i,
  input  wire  [fpalu_pkg::DataW-1:0]  operand_b_i,
  output logic                         result_valid_o,
  output logic [fpalu_pkg::DataW-1:0]  result_value_o,
  output logic                         less_flag_o,
  output logic                         equal_flag_o,
  output logic                         greater_flag_o,
  output logic                         overflow_flag_o,
  output logic                         div_zero_flag_o
);
  import fpalu_pkg::*;
`include "assert_macros.svh"

  localparam int NStg = DivStages + 1;

  // Never stall the sender: every stage advances each cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic             vld0_q;
  logic [CmdW-1:0]  cmd0_q;
  logic [DataW-1:0] a0_q, b0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd0_q <= cmd_i;
    a0_q   <= operand_a_i;
    b0_q   <= operand_b_i;
  end

  // ---------------------------------------------------------------------
  // Setup stage: compare flags, simple operations, product, divider init
  // ---------------------------------------------------------------------
  pipe_t                p_q [1:NStg];
  pipe_t                p_d [1:NStg];
  logic [2*DataW-1:0]   prod_q, prod_d;

  always_comb begin
    logic signed [WideW-1:0] sa, sb;
    logic [DataW-1:0]        ma, mb;
    sat_t                    s;
    sa = {{(WideW - DataW){a0_q[DataW-1]}}, a0_q};
    sb = {{(WideW - DataW){b0_q[DataW-1]}}, b0_q};
    ma = a0_q[DataW-1] ? (~a0_q + 1'b1) : a0_q;
    mb = b0_q[DataW-1] ? (~b0_q + 1'b1) : b0_q;
    s  = '0;

    p_d[1].vld = vld0_q;
    p_d[1].cmd = cmd0_q;
    p_d[1].lt  = $signed(a0_q) < $signed(b0_q);
    p_d[1].eq  = a0_q == b0_q;
    p_d[1].gt  = $signed(a0_q) > $signed(b0_q);

    case (cmd0_q)
      CmdAdd:     s = sat_fn(sa + sb);
      CmdSub:     s = sat_fn(sa - sb);
      CmdMin:     s.res = ($signed(a0_q) <= $signed(b0_q)) ? a0_q : b0_q;
      CmdMax:     s.res = ($signed(a0_q) >= $signed(b0_q)) ? a0_q : b0_q;
      CmdInc:     s = sat_fn(sa + WideW'(1));
      CmdDec:     s = sat_fn(sa - WideW'(1));
      CmdToInt:   s.res = DataW'($signed(a0_q) >>> FracBits);
      CmdFromInt: s = sat_fn(sa <<< FracBits);
      default:    s = '0;
    endcase

    p_d[1].res = s.res;
    p_d[1].ovf = s.ovf;
    p_d[1].neg = a0_q[DataW-1] ^ b0_q[DataW-1];
    p_d[1].nq  = {ma, {FracBits{1'b0}}};
    p_d[1].rem = '0;
    p_d[1].den = mb;
    prod_d     = ma * mb;
  end

  // ---------------------------------------------------------------------
  // Divider stages; the first one also rounds the product
  // ---------------------------------------------------------------------
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_comb begin
      pipe_t                   nxt;
      logic [DataW:0]          t;
      logic                    qb;
      logic [WideW-1:0]        pw;
      logic signed [WideW-1:0] mv;
      sat_t                    s;
      nxt = p_q[k];
      t   = '0;
      qb  = 1'b0;
      for (int j = 0; j < DivRadixBits; j++) begin
        if ((k - 1) * DivRadixBits + j < QuoW) begin
          t = {nxt.rem, nxt.nq[QuoW-1]};
          if (t >= {1'b0, nxt.den}) begin
            t  = t - {1'b0, nxt.den};
            qb = 1'b1;
          end else begin
            qb = 1'b0;
          end
          nxt.rem = t[DataW-1:0];
          nxt.nq  = {nxt.nq[QuoW-2:0], qb};
        end
      end
      // Round half away from zero on the magnitude, then apply the sign.
      pw = ({2'b00, prod_q} + (WideW'(1) << (FracBits - 1))) >> FracBits;
      mv = p_q[k].neg ? -$signed(pw) : $signed(pw);
      s  = sat_fn(mv);
      if (k == 1 && p_q[k].cmd == CmdMul) begin
        nxt.res = s.res;
        nxt.ovf = s.ovf;
      end
      p_d[k+1] = nxt;
    end
  end

  // Clear the valid bit on reset; hold the payload until reset lifts.
  for (genvar k = 1; k <= NStg; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_q[k].vld <= 1'b0;
      end else begin
        p_q[k] <= p_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------------
  // Final stage: round the quotient, sign, saturate, select
  // ---------------------------------------------------------------------
  logic             out_vld_d, out_vld_q;
  logic [DataW-1:0] out_res_d, out_res_q;
  logic             out_ovf_d, out_ovf_q;
  logic             out_dz_d, out_dz_q;
  logic             out_lt_q, out_eq_q, out_gt_q;

  always_comb begin
    logic [QuoW-1:0]         qr;
    logic signed [WideW-1:0] dv;
    sat_t                    s;
    // Round up when twice the remainder reaches the divisor.
    qr = p_q[NStg].nq
       + QuoW'({p_q[NStg].rem, 1'b0} >= {1'b0, p_q[NStg].den});
    dv = p_q[NStg].neg ? -$signed(WideW'(qr)) : $signed(WideW'(qr));
    s  = sat_fn(dv);

    out_vld_d = p_q[NStg].vld;
    out_res_d = p_q[NStg].res;
    out_ovf_d = p_q[NStg].ovf;
    out_dz_d  = 1'b0;
    if (p_q[NStg].cmd == CmdDiv) begin
      if (p_q[NStg].den == '0) begin
        out_res_d = '0;
        out_ovf_d = 1'b0;
        out_dz_d  = 1'b1;
      end else begin
        out_res_d = s.res;
        out_ovf_d = s.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
    out_ovf_q <= out_ovf_d;
    out_dz_q  <= out_dz_d;
    out_lt_q  <= p_q[NStg].lt;
    out_eq_q  <= p_q[NStg].eq;
    out_gt_q  <= p_q[NStg].gt;
  end

  assign result_valid_o  = out_vld_q;
  assign result_value_o  = out_res_q;
  assign less_flag_o     = out_lt_q;
  assign equal_flag_o    = out_eq_q;
  assign greater_flag_o  = out_gt_q;
  assign overflow_flag_o = out_ovf_q;
  assign div_zero_flag_o = out_dz_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_one_relation, result_valid_o |-> ($onehot({less_flag_o, equal_flag_o, greater_flag_o})))
  `ASSERT_NEVER(a_dz_no_ovf, result_valid_o && div_zero_flag_o && overflow_flag_o)
  `ASSERT_CLK(a_dz_zero, (result_valid_o && div_zero_flag_o) |-> (result_value_o == '0))
  `ASSERT_CLK(a_ovf_bound, (result_valid_o && overflow_flag_o) |-> ((result_value_o == SatMax[DataW-1:0]) || (result_value_o == SatMin[DataW-1:0])))

endmodule

`default_nettype wire
